@@ hw/rtl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

  // Channel and code width
  localparam int CHAN_W = 8;

  // Input word: one RGB pixel
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  // Output word: one HSV pixel
  typedef struct packed {
    logic [CHAN_W-1:0] hue_out;
    logic [CHAN_W-1:0] sat_out;
    logic [CHAN_W-1:0] val_out;
  } hsv_t;

endpackage

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter, 8 bits per channel. One pixel word is accepted every
// clock unless the output word is stalled. Three stages find max/min,
// the hue sector and the two dividends, then eight restoring-division stages
// produce one quotient bit each for saturation and hue side by side. While
// a finished word is stalled the whole pipeline holds and in_ready drops with
// it, so no word is lost or repeated. Value is the largest channel, saturation is
// floor(255*(max-min)/max), hue is floor(H*85/(2*(max-min))) with H in sector
// units scaled by max-min (full circle maps to 0..254). Black and grey pixels
// give hue 0 and saturation 0; ties for the maximum go red, then green, then blue.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hsv_t   out_data
);

  localparam int NUM_W   = 17;          // dividend width, 255*510 < 2^17
  localparam int DIV_STG = CHAN_W;      // one quotient bit per stage
  localparam int NSTG    = DIV_STG + 3; // total pipeline depth

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    max_sel_t          sel;
    logic [CHAN_W:0]   hdiff;   // signed difference term
  } s1_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] d;
    logic [10:0]       h;       // sector position, 0..1529
  } s2_t;

  typedef struct packed {
    logic [NUM_W-1:0]  sat_rem;
    logic [NUM_W-1:0]  hue_rem;
    logic [CHAN_W-1:0] sat_div;
    logic [CHAN_W:0]   hue_div;
    logic [CHAN_W-1:0] sat_q;
    logic [CHAN_W-1:0] hue_q;
    logic [CHAN_W-1:0] val;
  } dv_t;

  logic [NSTG-1:0] vld_r;
  logic            adv;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  dv_t dv_r   [DIV_STG+1];
  dv_t dv_nxt [DIV_STG+1];

  // Global advance: pipeline moves unless the output word is stalled
  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = '{hue_out: dv_r[DIV_STG].hue_q,
                       sat_out: dv_r[DIV_STG].sat_q,
                       val_out: dv_r[DIV_STG].val};

  // Stage 1: max, min, winning channel and difference term
  always_comb begin
    logic r_max, g_max;
    r_max = (in_data.red_in >= in_data.green_in) && (in_data.red_in >= in_data.blue_in);
    g_max = (in_data.green_in >= in_data.red_in) && (in_data.green_in >= in_data.blue_in);
    s1_nxt = '0;
    if (r_max) begin
      s1_nxt.sel   = SEL_RED;
      s1_nxt.mx    = in_data.red_in;
      s1_nxt.hdiff = {1'b0, in_data.green_in} - {1'b0, in_data.blue_in};
    end else if (g_max) begin
      s1_nxt.sel   = SEL_GREEN;
      s1_nxt.mx    = in_data.green_in;
      s1_nxt.hdiff = {1'b0, in_data.blue_in} - {1'b0, in_data.red_in};
    end else begin
      s1_nxt.sel   = SEL_BLUE;
      s1_nxt.mx    = in_data.blue_in;
      s1_nxt.hdiff = {1'b0, in_data.red_in} - {1'b0, in_data.green_in};
    end
    s1_nxt.mn = in_data.red_in;
    if (in_data.green_in < s1_nxt.mn) s1_nxt.mn = in_data.green_in;
    if (in_data.blue_in < s1_nxt.mn) s1_nxt.mn = in_data.blue_in;
  end

  // Stage 2: span, sector offset and negative wrap
  always_comb begin
    logic [CHAN_W-1:0] d;
    logic [10:0]       base;
    logic [10:0]       six_d;
    logic [11:0]       hp;
    d     = s1_r.mx - s1_r.mn;
    six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    case (s1_r.sel)
      SEL_RED:   base = '0;
      SEL_GREEN: base = {2'b00, d, 1'b0};
      SEL_BLUE:  base = {1'b0, d, 2'b00};
      default:   base = '0;
    endcase
    hp = {1'b0, base} + {{3{s1_r.hdiff[CHAN_W]}}, s1_r.hdiff};
    s2_nxt.mx = s1_r.mx;
    s2_nxt.d  = d;
    if (hp[11]) begin
      s2_nxt.h = hp[10:0] + six_d;
    end else begin
      s2_nxt.h = hp[10:0];
    end
  end

  // Stage 3 dividends (a zero divisor becomes 1 since its dividend is 0),
  // then the division stages: restoring step, MSB of the quotient first
  always_comb begin
    logic [NUM_W-1:0] sat_cmp;
    logic [NUM_W-1:0] hue_cmp;
    logic             sat_ge;
    logic             hue_ge;
    dv_nxt[0].sat_rem = NUM_W'({s2_r.d, 8'h00} - {8'h00, s2_r.d});
    dv_nxt[0].hue_rem = NUM_W'(NUM_W'(s2_r.h) * NUM_W'(85));
    dv_nxt[0].sat_div = (s2_r.mx == '0) ? CHAN_W'(1) : s2_r.mx;
    dv_nxt[0].hue_div = (s2_r.d == '0) ? (CHAN_W+1)'(1) : {s2_r.d, 1'b0};
    dv_nxt[0].sat_q   = '0;
    dv_nxt[0].hue_q   = '0;
    dv_nxt[0].val     = s2_r.mx;
    for (int k = 0; k < DIV_STG; k++) begin
      sat_cmp = NUM_W'(dv_r[k].sat_div) << (DIV_STG-1-k);
      hue_cmp = NUM_W'(dv_r[k].hue_div) << (DIV_STG-1-k);
      sat_ge  = dv_r[k].sat_rem >= sat_cmp;
      hue_ge  = dv_r[k].hue_rem >= hue_cmp;
      dv_nxt[k+1]         = dv_r[k];
      dv_nxt[k+1].sat_rem = sat_ge ? dv_r[k].sat_rem - sat_cmp : dv_r[k].sat_rem;
      dv_nxt[k+1].hue_rem = hue_ge ? dv_r[k].hue_rem - hue_cmp : dv_r[k].hue_rem;
      dv_nxt[k+1].sat_q   = {dv_r[k].sat_q[CHAN_W-2:0], sat_ge};
      dv_nxt[k+1].hue_q   = {dv_r[k].hue_q[CHAN_W-2:0], hue_ge};
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      for (int k = 0; k <= DIV_STG; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

endmodule

@@ hw/rtl/rgbhsv_checker.sv @@
module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input pixel_t in_data,
  input logic   out_valid,
  input logic   out_ready,
  input hsv_t   out_data
);

  // Input side stalls exactly when a finished word is held
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stall");

  // Waiting input word holds until accepted
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.val_out == '0) |->
      (out_data.sat_out == '0) && (out_data.hue_out == '0))
    else $error("black pixel with nonzero hue or saturation");

  // Hue circle tops out at 254
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue_out != 8'hFF)
    else $error("hue code out of range");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbhsv_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 9;
  localparam int RAND_WORDS = 500;
  localparam int TAIL_CYCLES = 20;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  pixel_t in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  hsv_t   out_data;

  pixel_t pixel_q[$];
  hsv_t   hsv_expect_q[$];
  int     err_count = 0;

  // driver and monitor pacing state
  int     send_gap = 0;
  int     stall_left = 0;
  bit     drv_calm = 1'b0;
  bit     mon_calm = 1'b0;

  rgb_to_hsv_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock and reset
  initial begin
    fork
      forever #(CLK_HALF) clk = ~clk;
    join_none
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    #2ms;
    $display("rgb_to_hsv_converter test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // integer HSV: hue in sector units scaled by max-min, wraps when negative
  function automatic hsv_t predict_hsv(input pixel_t px);
    int   r, g, b, mx, mn, d, h, sat, hue;
    hsv_t res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sat = (mx != 0) ? (255 * d) / mx : 0;
    hue = 0;
    if (d != 0) begin
      // tie order: red, then green, then blue
      if (r == mx) h = g - b;
      else if (g == mx) h = 2 * d + (b - r);
      else h = 4 * d + (r - g);
      if (h < 0) h += 6 * d;
      hue = (h * 85) / (2 * d);
    end
    res.hue_out = 8'(hue);
    res.sat_out = 8'(sat);
    res.val_out = 8'(mx);
    return res;
  endfunction

  function automatic logic [7:0] clamp_chan(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] edge_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // random pixel, biased toward small spans, ties, grey and extremes
  function automatic pixel_t rand_pixel();
    pixel_t px;
    int     base;
    px = pixel_t'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        base = $urandom_range(0, 255);
        px.red_in   = clamp_chan(base + $urandom_range(0, 4) - 2);
        px.green_in = clamp_chan(base + $urandom_range(0, 4) - 2);
        px.blue_in  = clamp_chan(base + $urandom_range(0, 4) - 2);
      end
      6: begin
        case ($urandom_range(0, 2))
          0: px.green_in = px.red_in;
          1: px.blue_in = px.green_in;
          default: px.blue_in = px.red_in;
        endcase
      end
      7: begin
        px.green_in = px.red_in;
        px.blue_in = px.red_in;
      end
      8: begin
        px.red_in   = edge_chan();
        px.green_in = edge_chan();
        px.blue_in  = edge_chan();
      end
      9: begin
        case ($urandom_range(0, 2))
          0: px.red_in = edge_chan();
          1: px.green_in = edge_chan();
          default: px.blue_in = edge_chan();
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  // driver: presents queued pixels, holds until accepted, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) hsv_expect_q.push_back(predict_hsv(in_data));
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
        if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
        send_gap <= drv_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result word, random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hsv_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          hsv_t exp_hsv;
          exp_hsv = hsv_expect_q.pop_front();
          if (out_data.hue_out !== exp_hsv.hue_out)
            report_mismatch($sformatf("hue %0d, expected %0d",
                                      out_data.hue_out, exp_hsv.hue_out));
          if (out_data.sat_out !== exp_hsv.sat_out)
            report_mismatch($sformatf("sat %0d, expected %0d",
                                      out_data.sat_out, exp_hsv.sat_out));
          if (out_data.val_out !== exp_hsv.val_out)
            report_mismatch($sformatf("val %0d, expected %0d",
                                      out_data.val_out, exp_hsv.val_out));
        end
        if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
        stall_left = mon_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of test
  initial begin
    pixel_t px;
    // directed: black, white, grey, primaries, ties, hue wrap, tiny spans
    pixel_q.push_back('{8'd0,   8'd0,   8'd0});
    pixel_q.push_back('{8'd255, 8'd255, 8'd255});
    pixel_q.push_back('{8'd128, 8'd128, 8'd128});
    pixel_q.push_back('{8'd1,   8'd1,   8'd1});
    pixel_q.push_back('{8'd255, 8'd0,   8'd0});
    pixel_q.push_back('{8'd0,   8'd255, 8'd0});
    pixel_q.push_back('{8'd0,   8'd0,   8'd255});
    pixel_q.push_back('{8'd255, 8'd255, 8'd0});
    pixel_q.push_back('{8'd0,   8'd255, 8'd255});
    pixel_q.push_back('{8'd255, 8'd0,   8'd255});
    pixel_q.push_back('{8'd255, 8'd0,   8'd1});
    pixel_q.push_back('{8'd255, 8'd254, 8'd0});
    pixel_q.push_back('{8'd1,   8'd0,   8'd0});
    pixel_q.push_back('{8'd0,   8'd1,   8'd0});
    pixel_q.push_back('{8'd0,   8'd0,   8'd1});
    pixel_q.push_back('{8'd1,   8'd0,   8'd1});
    pixel_q.push_back('{8'd200, 8'd100, 8'd150});
    pixel_q.push_back('{8'd100, 8'd200, 8'd50});
    pixel_q.push_back('{8'd50,  8'd100, 8'd200});
    pixel_q.push_back('{8'd170, 8'd85,  8'd170});
    pixel_q.push_back('{8'd254, 8'd255, 8'd253});
    pixel_q.push_back('{8'd128, 8'd127, 8'd129});
    pixel_q.push_back('{8'd170, 8'd85,  8'd0});
    pixel_q.push_back('{8'd85,  8'd170, 8'd85});
    for (int i = 0; i < RAND_WORDS; i++) begin
      px = rand_pixel();
      pixel_q.push_back(px);
    end

    @(posedge rst_n);
    // drain: all words sent and every result word seen
    while (pixel_q.size() != 0 || in_valid || hsv_expect_q.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (hsv_expect_q.size() != 0)
      report_mismatch($sformatf("%0d result words missing", hsv_expect_q.size()));

    if (err_count == 0) begin
      $display("rgb_to_hsv_converter test passed");
    end else begin
      $display("rgb_to_hsv_converter test failed");
    end
    $finish;
  end

endmodule

@@ rgb_to_hsv_converter.f @@
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgb_to_hsv_converter.sv
hw/rtl/rgbhsv_checker.sv
sim/tb_top.sv
